// ----- design/siq_pkg.sv -----
// Package with shared types and codes for the sorted insert queue.
package siq_pkg;

    localparam logic KIND_INSERT = 1'b0;
    localparam logic KIND_REMOVE = 1'b1;

    typedef enum logic [1:0] {
        STATUS_DONE  = 2'd0,
        STATUS_RANGE = 2'd1,
        STATUS_FULL  = 2'd2
    } t_status;

    typedef struct packed {
        logic load;
        logic exec;
    } t_dp_cmd;

endpackage

// ----- design/sorted_insert_queue.sv -----
// Top level of the sorted insert queue: controller and datapath joined together.
// Keeps up to DEPTH signed keys in ascending order. An insert places its key in front of
// the first stored key that is greater than or equal to it; a remove erases the entry at
// the given position and returns the largest key as it stood before. Every transfer in
// yields exactly one result transfer with a status: done, position out of range (also a
// remove from an empty store), or store full; errors change nothing. An item is captured
// in the idle state; then, in the execute state, every cell compares its key with the new key
// in parallel and shifts in a single step. The next item is taken while a finished result
// still waits in the output register; only when that register is still held does the
// execute cycle wait for it.
module sorted_insert_queue
    import siq_pkg::*;
#(
    parameter int DEPTH     = 16,
    parameter int KEY_WIDTH = 32
) (
    input  logic                         i_clk,
    input  logic                         i_rst_n,
    input  logic                         i_valid,
    output logic                         o_stall,
    input  logic                         i_kind,
    input  logic [KEY_WIDTH-1:0]         i_new_key,
    input  logic [$clog2(DEPTH)-1:0]     i_position,
    output logic                         o_valid,
    input  logic                         i_stall,
    output logic [KEY_WIDTH-1:0]         o_largest_before,
    output logic [1:0]                   o_status,
    output logic [$clog2(DEPTH+1)-1:0]   o_count_after
);

    t_dp_cmd w_cmd;

    siq_ctrl u_ctrl (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (i_valid),
        .o_stall (o_stall),
        .o_valid (o_valid),
        .i_stall (i_stall),
        .o_cmd   (w_cmd)
    );

    siq_datapath #(
        .DEPTH     (DEPTH),
        .KEY_WIDTH (KEY_WIDTH)
    ) u_datapath (
        .i_clk            (i_clk),
        .i_rst_n          (i_rst_n),
        .i_cmd            (w_cmd),
        .i_kind           (i_kind),
        .i_new_key        (i_new_key),
        .i_position       (i_position),
        .o_largest_before (o_largest_before),
        .o_status         (o_status),
        .o_count_after    (o_count_after)
    );

endmodule

// ----- design/siq_ctrl.sv -----
// Controller state machine for the sorted insert queue: handshakes and datapath commands.
module siq_ctrl
    import siq_pkg::*;
(
    input  logic    i_clk,
    input  logic    i_rst_n,
    input  logic    i_valid,
    output logic    o_stall,
    output logic    o_valid,
    input  logic    i_stall,
    output t_dp_cmd o_cmd
);

    typedef enum logic {
        S_IDLE,
        S_EXEC
    } t_state;

    t_state r_state;
    logic   r_out_valid;

    assign o_stall     = (r_state != S_IDLE);
    assign o_valid     = r_out_valid;
    assign o_cmd.load  = (r_state == S_IDLE) && i_valid;
    assign o_cmd.exec  = (r_state == S_EXEC) && (!r_out_valid || !i_stall);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_out_valid <= 1'b0;
        end else begin
            unique case (r_state)
                S_IDLE: begin
                    if (i_valid) begin
                        r_state <= S_EXEC;
                    end
                end
                S_EXEC: begin
                    if (o_cmd.exec) begin
                        r_state <= S_IDLE;
                    end
                end
                default: begin
                    r_state <= S_IDLE;
                end
            endcase
            if (o_cmd.exec) begin
                r_out_valid <= 1'b1;
            end else if (r_out_valid && !i_stall) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    a_accept_then_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_valid && !o_stall) |=> o_stall)
        else $error("Controller took a second item before finishing the first.");

    a_valid_from_exec: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $rose(o_valid) |-> $past(o_cmd.exec))
        else $error("Result became valid without an execute command.");

    a_exec_slot_free: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_cmd.exec |-> (!r_out_valid || !i_stall))
        else $error("Execute would overwrite a result that was not transferred.");

endmodule

// ----- design/siq_datapath.sv -----
// Datapath for the sorted insert queue: a row of compare-and-shift cells and result registers.
module siq_datapath
    import siq_pkg::*;
#(
    parameter int DEPTH     = 16,
    parameter int KEY_WIDTH = 32,
    localparam int CW       = $clog2(DEPTH + 1),
    localparam int PW       = $clog2(DEPTH)
) (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  t_dp_cmd              i_cmd,
    input  logic                 i_kind,
    input  logic [KEY_WIDTH-1:0] i_new_key,
    input  logic [PW-1:0]        i_position,
    output logic [KEY_WIDTH-1:0] o_largest_before,
    output logic [1:0]           o_status,
    output logic [CW-1:0]        o_count_after
);

    logic                        r_kind;
    logic signed [KEY_WIDTH-1:0] r_key;
    logic [PW-1:0]               r_pos;
    logic [CW-1:0]               r_count;
    logic [CW-1:0]               n_count;
    logic signed [KEY_WIDTH-1:0] r_store [DEPTH];
    logic signed [KEY_WIDTH-1:0] n_store [DEPTH];
    logic [DEPTH-1:0]            w_before;
    logic [KEY_WIDTH-1:0]        r_largest;
    t_status                     r_status;
    t_status                     n_status;
    logic [CW-1:0]               w_last_idx;
    logic                        w_full;
    logic                        w_range_err;
    logic                        w_update;

    assign w_full      = (r_count == CW'(DEPTH));
    assign w_range_err = (CW'(r_pos) >= r_count);
    assign w_last_idx  = r_count - CW'(1);

    always_comb begin
        n_status = STATUS_DONE;
        n_count  = r_count;
        w_update = 1'b0;
        if (r_kind == KIND_INSERT) begin
            if (w_full) begin
                n_status = STATUS_FULL;
            end else begin
                n_count  = r_count + CW'(1);
                w_update = i_cmd.exec;
            end
        end else begin
            if (w_range_err) begin
                n_status = STATUS_RANGE;
            end else begin
                n_count  = r_count - CW'(1);
                w_update = i_cmd.exec;
            end
        end
    end

    for (genvar g = 0; g < DEPTH; g++) begin : g_cell
        logic signed [KEY_WIDTH-1:0] w_ins;
        logic signed [KEY_WIDTH-1:0] w_rem;

        assign w_before[g] = (CW'(g) < r_count) && (r_store[g] < r_key);

        if (g == 0) begin : g_first
            assign w_ins = w_before[g] ? r_store[g] : r_key;
        end else begin : g_rest
            assign w_ins = w_before[g] ? r_store[g] :
                           (w_before[g-1] ? r_key : r_store[g-1]);
        end

        if (g == DEPTH - 1) begin : g_last
            assign w_rem = r_store[g];
        end else begin : g_mid
            assign w_rem = (PW'(g) < r_pos) ? r_store[g] : r_store[g+1];
        end

        assign n_store[g] = (r_kind == KIND_INSERT) ? w_ins : w_rem;

        always_ff @(posedge i_clk) begin
            if (w_update) begin
                r_store[g] <= n_store[g];
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_count <= '0;
        end else if (i_cmd.exec) begin
            r_count <= n_count;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.load) begin
            r_kind <= i_kind;
            r_key  <= i_new_key;
            r_pos  <= i_position;
        end
        if (i_cmd.exec) begin
            r_status      <= n_status;
            o_count_after <= n_count;
            if (r_kind == KIND_REMOVE && !w_range_err) begin
                r_largest <= r_store[w_last_idx[PW-1:0]];
            end else begin
                r_largest <= '0;
            end
        end
    end

    assign o_largest_before = r_largest;
    assign o_status         = r_status;

    a_count_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_count <= CW'(DEPTH))
        else $error("Entry count exceeds the store depth.");

    a_insert_grows: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_cmd.exec && r_kind == KIND_INSERT && !w_full)
            |=> r_count == $past(r_count) + CW'(1))
        else $error("Successful insert did not add one entry.");

    a_bad_remove_holds: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_cmd.exec && r_kind == KIND_REMOVE && w_range_err)
            |=> r_count == $past(r_count))
        else $error("Rejected remove changed the entry count.");

endmodule

// ----- test/tb_top.sv -----
// Self-checking testbench for the sorted insert queue, with a per-item prediction of its store.
module tb_top;
    import siq_pkg::*;

    localparam int DEPTH      = 16;
    localparam int KEY_W      = 32;
    localparam int POS_W      = $clog2(DEPTH);
    localparam int CNT_W      = $clog2(DEPTH + 1);
    localparam int WATCH_MAX  = 5000;

    typedef struct {
        logic signed [KEY_W-1:0] largest;
        t_status                 status;
        logic [CNT_W-1:0]        count;
    } t_outcome;

    logic                 i_clk = 1'b0;
    logic                 i_rst_n = 1'b0;
    logic                 i_valid = 1'b0;
    logic                 o_stall;
    logic                 i_kind = KIND_INSERT;
    logic [KEY_W-1:0]     i_new_key = '0;
    logic [POS_W-1:0]     i_position = '0;
    logic                 o_valid;
    logic                 i_stall = 1'b0;
    logic [KEY_W-1:0]     o_largest_before;
    logic [1:0]           o_status;
    logic [CNT_W-1:0]     o_count_after;

    logic signed [KEY_W-1:0] model_keys [DEPTH];
    int                      model_count = 0;
    t_outcome                pending_outcomes [$];

    int send_idle_pct = 0;
    int recv_stall_pct = 0;
    int hold_left = 0;
    int quiet_cycles = 0;
    int mismatches = 0;
    int items_sent = 0;
    int results_checked = 0;
    int full_rejects = 0;
    int range_rejects = 0;
    int max_fill_hits = 0;

    sorted_insert_queue #(
        .DEPTH     (DEPTH),
        .KEY_WIDTH (KEY_W)
    ) u_dut (
        .i_clk            (i_clk),
        .i_rst_n          (i_rst_n),
        .i_valid          (i_valid),
        .o_stall          (o_stall),
        .i_kind           (i_kind),
        .i_new_key        (i_new_key),
        .i_position       (i_position),
        .o_valid          (o_valid),
        .i_stall          (i_stall),
        .o_largest_before (o_largest_before),
        .o_status         (o_status),
        .o_count_after    (o_count_after)
    );

    always begin
        #5 i_clk = 1'b1;
        #5 i_clk = 1'b0;
    end

    task automatic report_mismatch(input string what);
        if (mismatches < 40) begin
            $display("[%0t] mismatch: %s", $realtime, what);
        end
        mismatches++;
    endtask

    function automatic void predict_outcome(input logic kind, input logic signed [KEY_W-1:0] key,
                                            input logic [POS_W-1:0] pos);
        t_outcome res;
        int       at;
        res.largest = '0;
        res.status  = STATUS_DONE;
        if (kind == KIND_INSERT) begin
            if (model_count >= DEPTH) begin
                res.status = STATUS_FULL;
                full_rejects++;
            end else begin
                at = 0;
                while (at < model_count && model_keys[at] < key) begin
                    at++;
                end
                for (int i = model_count; i > at; i--) begin
                    model_keys[i] = model_keys[i-1];
                end
                model_keys[at] = key;
                model_count++;
                if (model_count == DEPTH) begin
                    max_fill_hits++;
                end
            end
        end else begin
            if (model_count == 0 || int'(pos) >= model_count) begin
                res.status = STATUS_RANGE;
                range_rejects++;
            end else begin
                res.largest = model_keys[model_count-1];
                for (int i = int'(pos); i + 1 < model_count; i++) begin
                    model_keys[i] = model_keys[i+1];
                end
                model_count--;
            end
        end
        res.count = CNT_W'(model_count);
        pending_outcomes = {pending_outcomes, res};
    endfunction

    // Called right after a rising edge; returns at the edge where the transfer happened.
    task automatic offer_item(input logic kind, input logic [KEY_W-1:0] key,
                              input logic [POS_W-1:0] pos);
        while ($urandom_range(99) < send_idle_pct) begin
            i_valid <= 1'b0;
            @(posedge i_clk);
        end
        i_valid    <= 1'b1;
        i_kind     <= kind;
        i_new_key  <= key;
        i_position <= pos;
        do @(posedge i_clk); while (o_stall);
        predict_outcome(kind, key, pos);
        items_sent++;
    endtask

    task automatic drain_queue();
        i_valid <= 1'b0;
        @(posedge i_clk);
        while (pending_outcomes.size() != 0) begin
            @(posedge i_clk);
        end
    endtask

    task automatic set_pace(input int sender_pct, input int receiver_pct);
        @(negedge i_clk);
        send_idle_pct  = sender_pct;
        recv_stall_pct = receiver_pct;
        @(posedge i_clk);
    endtask

    function automatic logic [KEY_W-1:0] pick_key();
        case ($urandom_range(3))
            0: return KEY_W'($urandom);
            1: return KEY_W'(int'($urandom_range(15)) - 8);
            2: begin
                case ($urandom_range(3))
                    0: return {1'b0, {(KEY_W-1){1'b1}}};
                    1: return {1'b1, {(KEY_W-1){1'b0}}};
                    2: return '0;
                    default: return '1;
                endcase
            end
            default: begin
                if (model_count > 0) begin
                    return model_keys[$urandom_range(model_count - 1)];
                end
                return KEY_W'($urandom);
            end
        endcase
    endfunction

    function automatic logic [POS_W-1:0] pick_position();
        if (model_count > 0 && $urandom_range(99) < 80) begin
            return POS_W'($urandom_range(model_count - 1));
        end
        return POS_W'($urandom_range(DEPTH - 1));
    endfunction

    task automatic test_directed_cases();
        set_pace(0, 0);
        offer_item(KIND_REMOVE, '0, '0);
        offer_item(KIND_INSERT, 32'h7fff_ffff, '1);
        offer_item(KIND_INSERT, 32'h8000_0000, '0);
        offer_item(KIND_INSERT, 32'h0000_0000, '0);
        offer_item(KIND_INSERT, 32'h0000_0000, '1);
        offer_item(KIND_INSERT, 32'hffff_ffff, '0);
        offer_item(KIND_REMOVE, '1, POS_W'(5));
        offer_item(KIND_REMOVE, '0, POS_W'(15));
        offer_item(KIND_REMOVE, '0, POS_W'(2));
        offer_item(KIND_REMOVE, '0, POS_W'(3));
        while (model_count < DEPTH) begin
            offer_item(KIND_INSERT, pick_key(), POS_W'($urandom));
        end
        offer_item(KIND_INSERT, 32'h1234_5678, '0);
        offer_item(KIND_REMOVE, '0, POS_W'(15));
        drain_queue();
    endtask

    task automatic test_random_traffic(input int n, input int sender_pct,
                                       input int receiver_pct);
        int insert_pct;
        set_pace(sender_pct, receiver_pct);
        insert_pct = 50;
        for (int k = 0; k < n; k++) begin
            if (k % 40 == 0) begin
                case ($urandom_range(2))
                    0: insert_pct = 15;
                    1: insert_pct = 50;
                    default: insert_pct = 85;
                endcase
            end
            if ($urandom_range(99) < insert_pct) begin
                offer_item(KIND_INSERT, pick_key(), POS_W'($urandom));
            end else begin
                offer_item(KIND_REMOVE, KEY_W'($urandom), pick_position());
            end
        end
        drain_queue();
    endtask

    // The receiver holds off long enough for a held result to block execution and stall the input.
    task automatic test_full_backpressure();
        set_pace(0, 0);
        @(negedge i_clk);
        hold_left = 300;
        @(posedge i_clk);
        for (int k = 0; k < 60; k++) begin
            if ($urandom_range(1) == 0) begin
                offer_item(KIND_INSERT, pick_key(), POS_W'($urandom));
            end else begin
                offer_item(KIND_REMOVE, KEY_W'($urandom), pick_position());
            end
        end
        drain_queue();
    endtask

    always @(posedge i_clk) begin
        if (hold_left > 0) begin
            i_stall <= 1'b1;
            hold_left = hold_left - 1;
        end else begin
            i_stall <= ($urandom_range(99) < recv_stall_pct);
        end
    end

    always @(posedge i_clk) begin
        t_outcome want;
        if (i_rst_n && o_valid && !i_stall) begin
            results_checked++;
            if (pending_outcomes.size() == 0) begin
                report_mismatch("result transfer with no item outstanding");
            end else begin
                want = pending_outcomes.pop_front();
                if (o_largest_before !== want.largest) begin
                    report_mismatch($sformatf("largest_before %0d, expected %0d",
                                              $signed(o_largest_before), want.largest));
                end
                if (o_status !== want.status) begin
                    report_mismatch($sformatf("status %0d, expected %0d",
                                              o_status, want.status));
                end
                if (o_count_after !== want.count) begin
                    report_mismatch($sformatf("count_after %0d, expected %0d",
                                              o_count_after, want.count));
                end
            end
        end
    end

    always @(posedge i_clk) begin
        if ((i_valid && o_stall === 1'b0) || (o_valid === 1'b1 && !i_stall)) begin
            quiet_cycles <= 0;
        end else if (quiet_cycles + 1 >= WATCH_MAX) begin
            $display("timeout: no transfer for %0d cycles", WATCH_MAX);
            $display("CHECK FAILED");
            $finish;
        end else begin
            quiet_cycles <= quiet_cycles + 1;
        end
    end

    initial begin
        repeat (6) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);
        test_directed_cases();
        test_random_traffic(450, 0, 0);
        test_random_traffic(450, 48, 0);
        test_random_traffic(450, 0, 48);
        test_random_traffic(450, 21, 21);
        test_full_backpressure();
        repeat (20) @(posedge i_clk);
        $display("%0d items sent and %0d results checked with the sender and receiver pacing varied.",
                 items_sent, results_checked);
        $display("Store filled %0d times, %0d inserts refused as full, %0d removes refused.",
                 max_fill_hits, full_rejects, range_rejects);
        if (mismatches == 0 && pending_outcomes.size() == 0) begin
            $display("CHECK OK");
        end else begin
            $display("CHECK FAILED");
        end
        $finish;
    end

endmodule
